### src/emissary_lru_victim_select_defines.svh
// Assertion macros for the LRU victim select block.
`ifndef EMISSARY_LRU_VICTIM_SELECT_DEFINES_SVH
`define EMISSARY_LRU_VICTIM_SELECT_DEFINES_SVH

`ifndef SYNTH
`define LRUVS_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LRUVS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define LRUVS_CHECK(lbl, prop, msg)
`define LRUVS_NEVER(lbl, cond, msg)
`endif

`endif

### src/lruvs_pkg.sv
// Shared constants, codes and types of the LRU victim select block.
package lruvs_pkg;

	localparam int NUM_SETS_DEF   = 64;
	localparam int NUM_WAYS_DEF   = 8;
	localparam int STAMP_BITS_DEF = 32;
	localparam int QUEUE_DEPTH    = 2;

	localparam int ACTION_W   = 2;
	localparam int SET_IDX_W  = 6;
	localparam int WAY_IDX_W  = 3;
	localparam int PCT_W      = 7;
	localparam int LIMIT_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int RES_W      = WAY_IDX_W + 1;

	localparam logic [ACTION_W-1:0] ACT_TOUCH = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_FILL  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_INVAL = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROMO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PF_EN = 2'd2;

	localparam logic [PCT_W-1:0] PCT_ALWAYS = 7'd100;
	localparam logic [PCT_W-1:0] PCT_NEVER  = 7'd0;

	typedef struct packed {
		logic clearing;
		logic query_busy;
		logic res_push;
	} status_t;

endpackage

### src/lruvs_fifo.sv
// Small queue with registered entries.
module lruvs_fifo #(
	parameter int WIDTH = 4,
	parameter int DEPTH = lruvs_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### src/lruvs_front.sv
// Front end: configuration registers, use counter and request classification.
module lruvs_front #(
	parameter int NUM_SETS   = lruvs_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS   = lruvs_pkg::NUM_WAYS_DEF,
	parameter int STAMP_BITS = lruvs_pkg::STAMP_BITS_DEF,
	parameter int SET_W      = 6,
	parameter int WAY_W      = 3,
	parameter int CMD_W      = 2 + SET_W + WAY_W + STAMP_BITS + 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lruvs_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [lruvs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            take,
	input  logic [lruvs_pkg::ACTION_W-1:0]  action,
	input  logic [lruvs_pkg::SET_IDX_W-1:0] set_index,
	input  logic [lruvs_pkg::WAY_IDX_W-1:0] way_index,
	input  logic                            prefetch_marked,
	input  logic [lruvs_pkg::PCT_W-1:0]     random_percent,
	output logic                            cmd_valid,
	output logic [CMD_W-1:0]                cmd_data,
	output logic [lruvs_pkg::LIMIT_W-1:0]   limit
);
	localparam int TBL_N = 2 ** lruvs_pkg::SET_IDX_W;

	logic [lruvs_pkg::LIMIT_W-1:0]  limit_q;
	logic [lruvs_pkg::PCT_W-1:0]    promo_q;
	logic                           pf_en_q;
	logic [STAMP_BITS-1:0]          ctr_q;
	logic [SET_W-1:0]               wrap_tbl [TBL_N];
	logic                           way_ok, promote, stamps;
	logic [lruvs_pkg::ACTION_W-1:0] op;
	logic [STAMP_BITS-1:0]          stamp;

	// set number wraps modulo the set count; worked out per entry at elaboration
	for (genvar g = 0; g < TBL_N; g++) begin : g_wrap
		assign wrap_tbl[g] = SET_W'(g % NUM_SETS);
	end

	assign way_ok  = int'(way_index) < NUM_WAYS;
	assign promote = pf_en_q && prefetch_marked &&
		(promo_q == lruvs_pkg::PCT_ALWAYS ||
		 (promo_q != lruvs_pkg::PCT_NEVER && random_percent < promo_q));
	assign stamps  = (action == lruvs_pkg::ACT_TOUCH) || (action == lruvs_pkg::ACT_FILL);

	// an invalidate is a fill with a zero stamp and no protection
	assign op    = (action == lruvs_pkg::ACT_INVAL) ? lruvs_pkg::ACT_FILL : action;
	assign stamp = (action == lruvs_pkg::ACT_INVAL) ? '0 : ctr_q;

	assign cmd_valid = take && ((action == lruvs_pkg::ACT_QUERY) || way_ok);
	assign cmd_data  = {op, wrap_tbl[set_index], WAY_W'(way_index), stamp,
		(action == lruvs_pkg::ACT_FILL) && promote};
	assign limit     = limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
			promo_q <= '0;
			pf_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				lruvs_pkg::CFG_LIMIT: limit_q <= cfg_wdata[lruvs_pkg::LIMIT_W-1:0];
				lruvs_pkg::CFG_PROMO: promo_q <= cfg_wdata[lruvs_pkg::PCT_W-1:0];
				lruvs_pkg::CFG_PF_EN: pf_en_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// hold at the top value once reached
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= STAMP_BITS'(1);
		end else if (take && way_ok && stamps && ctr_q != '1) begin
			ctr_q <= ctr_q + 1'b1;
		end
	end

endmodule

### src/lruvs_back.sv
// Back end: replacement state memory, clearing pass and victim search.
module lruvs_back #(
	parameter int NUM_SETS   = lruvs_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS   = lruvs_pkg::NUM_WAYS_DEF,
	parameter int STAMP_BITS = lruvs_pkg::STAMP_BITS_DEF,
	parameter int SET_W      = 6,
	parameter int WAY_W      = 3,
	parameter int CMD_W      = 2 + SET_W + WAY_W + STAMP_BITS + 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [lruvs_pkg::LIMIT_W-1:0]  limit,
	input  logic                           cmd_empty,
	input  logic [CMD_W-1:0]               cmd_data,
	output logic                           cmd_pop,
	input  logic                           res_full,
	output logic [lruvs_pkg::RES_W-1:0]    res_data,
	output lruvs_pkg::status_t             status
);
	localparam int STAMP_LSB = 1;
	localparam int WAY_LSB   = STAMP_LSB + STAMP_BITS;
	localparam int SET_LSB   = WAY_LSB + WAY_W;
	localparam int OP_LSB    = SET_LSB + SET_W;
	localparam int CNT_W     = $clog2(NUM_WAYS + 1);
	localparam int CMP_W     = (CNT_W > lruvs_pkg::LIMIT_W) ? CNT_W : lruvs_pkg::LIMIT_W;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_COUNT = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [NUM_WAYS-1:0][STAMP_BITS-1:0] stamp_mem [NUM_SETS];
	logic [NUM_WAYS-1:0]                 prot_mem  [NUM_SETS];

	logic [2:0]                          state_q;
	logic [SET_W-1:0]                    clr_q;
	logic [WAY_W-1:0]                    scan_q, best_q;
	logic                                found_q, prefer_q;
	logic [STAMP_BITS-1:0]               best_stamp_q;
	logic [NUM_WAYS-1:0][STAMP_BITS-1:0] rd_stamp_q;
	logic [NUM_WAYS-1:0]                 rd_prot_q;

	logic [lruvs_pkg::ACTION_W-1:0] op;
	logic [SET_W-1:0]               set;
	logic [WAY_W-1:0]               way;
	logic [STAMP_BITS-1:0]          stamp;
	logic                           prot;
	logic                           wr_en, rd_en, clearing, last_way, better;
	logic [CNT_W-1:0]               prot_cnt;

	assign op    = cmd_data[OP_LSB +: lruvs_pkg::ACTION_W];
	assign set   = cmd_data[SET_LSB +: SET_W];
	assign way   = cmd_data[WAY_LSB +: WAY_W];
	assign stamp = cmd_data[STAMP_LSB +: STAMP_BITS];
	assign prot  = cmd_data[0];

	assign clearing = (state_q == ST_CLEAR);
	assign cmd_pop  = (state_q == ST_IDLE) && !cmd_empty;
	assign wr_en    = cmd_pop && (op != lruvs_pkg::ACT_QUERY);
	assign rd_en    = cmd_pop && (op == lruvs_pkg::ACT_QUERY);
	assign last_way = (scan_q == WAY_W'(NUM_WAYS - 1));
	assign prot_cnt = CNT_W'($countones(rd_prot_q));

	// skip protected ways when unprotected ones are preferred
	assign better = !(prefer_q && rd_prot_q[scan_q]) &&
		(!found_q || rd_stamp_q[scan_q] < best_stamp_q);

	assign res_data = {lruvs_pkg::WAY_IDX_W'(best_q), rd_prot_q[best_q]};

	assign status.clearing   = clearing;
	assign status.query_busy = !clearing && (state_q != ST_IDLE);
	assign status.res_push   = (state_q == ST_DONE) && !res_full;

	always_ff @(posedge clk) begin
		if (clearing) begin
			stamp_mem[clr_q] <= '0;
			prot_mem[clr_q]  <= '0;
		end else if (wr_en) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (way == WAY_W'(w)) begin
					stamp_mem[set][w] <= stamp;
					if (op == lruvs_pkg::ACT_FILL) begin
						prot_mem[set][w] <= prot;
					end
				end
			end
		end
		if (rd_en) begin
			rd_stamp_q <= stamp_mem[set];
			rd_prot_q  <= prot_mem[set];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_COUNT: begin
				prefer_q <= (CMP_W'(prot_cnt) < CMP_W'(limit)) &&
					(prot_cnt != CNT_W'(NUM_WAYS));
			end
			ST_SCAN: begin
				if (better) begin
					best_q       <= scan_q;
					best_stamp_q <= rd_stamp_q[scan_q];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			scan_q  <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(NUM_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (rd_en) begin
						state_q <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					scan_q  <= '0;
					found_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (better) begin
						found_q <= 1'b1;
					end
					scan_q <= scan_q + 1'b1;
					if (last_way) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the result queue has room
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### src/emissary_lru_victim_select.sv
// Top level of the LRU victim select block with protected ways.
//
//  channel   handshake        payload
//  request   push / full      action, set_index, way_index, prefetch_marked,
//                             random_percent
//  result    empty / pop      victim_way, victim_protected
//  config    cfg_we           cfg_addr, cfg_wdata
//
// Requests are taken up to one per cycle, while full is low, into a two-entry queue ahead of the back end.
// Touch, fill and invalidate are each one masked row write in the back end.
// A victim query goes through a row read, the protected count, one way per
// cycle through the oldest-stamp compare, then the push into the result queue.
// Reset starts a clearing pass, one set a cycle through all NUM_SETS sets, with full held high.
// A full result queue holds the back end; full rises once the request queue fills behind it.
module emissary_lru_victim_select #(
	parameter int NUM_SETS   = lruvs_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS   = lruvs_pkg::NUM_WAYS_DEF,
	parameter int STAMP_BITS = lruvs_pkg::STAMP_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lruvs_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [lruvs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             push,
	output logic                             full,
	input  logic [lruvs_pkg::ACTION_W-1:0]   action,
	input  logic [lruvs_pkg::SET_IDX_W-1:0]  set_index,
	input  logic [lruvs_pkg::WAY_IDX_W-1:0]  way_index,
	input  logic                             prefetch_marked,
	input  logic [lruvs_pkg::PCT_W-1:0]      random_percent,
	output logic                             empty,
	input  logic                             pop,
	output logic [lruvs_pkg::WAY_IDX_W-1:0]  victim_way,
	output logic                             victim_protected
);
	`include "emissary_lru_victim_select_defines.svh"

	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W = $clog2(NUM_WAYS);
	localparam int CMD_W = lruvs_pkg::ACTION_W + SET_W + WAY_W + STAMP_BITS + 1;

	logic                           take, cmd_valid, cmd_full, cmd_empty, cmd_pop, res_full;
	logic [CMD_W-1:0]               cmd_in, cmd_out;
	logic [lruvs_pkg::LIMIT_W-1:0]  limit;
	logic [lruvs_pkg::RES_W-1:0]    res_in, res_out;
	lruvs_pkg::status_t             status;

	assign full = cmd_full || status.clearing;
	assign take = push && !full;

	lruvs_front #(
		.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .STAMP_BITS(STAMP_BITS),
		.SET_W(SET_W), .WAY_W(WAY_W), .CMD_W(CMD_W)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.take(take), .action(action), .set_index(set_index), .way_index(way_index),
		.prefetch_marked(prefetch_marked), .random_percent(random_percent),
		.cmd_valid(cmd_valid), .cmd_data(cmd_in), .limit(limit)
	);

	lruvs_fifo #(.WIDTH(CMD_W), .DEPTH(lruvs_pkg::QUEUE_DEPTH)) u_cmd_q (
		.clk(clk), .arst_n(arst_n),
		.push(cmd_valid), .wr_data(cmd_in), .full(cmd_full),
		.pop(cmd_pop), .rd_data(cmd_out), .empty(cmd_empty)
	);

	lruvs_back #(
		.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .STAMP_BITS(STAMP_BITS),
		.SET_W(SET_W), .WAY_W(WAY_W), .CMD_W(CMD_W)
	) u_back (
		.clk(clk), .arst_n(arst_n), .limit(limit),
		.cmd_empty(cmd_empty), .cmd_data(cmd_out), .cmd_pop(cmd_pop),
		.res_full(res_full), .res_data(res_in), .status(status)
	);

	lruvs_fifo #(.WIDTH(lruvs_pkg::RES_W), .DEPTH(lruvs_pkg::QUEUE_DEPTH)) u_res_q (
		.clk(clk), .arst_n(arst_n),
		.push(status.res_push), .wr_data(res_in), .full(res_full),
		.pop(pop), .rd_data(res_out), .empty(empty)
	);

	assign victim_way       = res_out[lruvs_pkg::RES_W-1:1];
	assign victim_protected = res_out[0];

	`LRUVS_CHECK(a_clear_once, !status.clearing |=> !status.clearing, "clearing pass restarted")
	`LRUVS_CHECK(a_full_in_clear, status.clearing |-> full, "request taken during clearing")
	`LRUVS_CHECK(a_push_in_query, status.res_push |-> status.query_busy, "result without query")
	`LRUVS_CHECK(a_victim_range, !empty |-> (NUM_WAYS > 8 || int'(victim_way) < NUM_WAYS), "victim way out of range")

endmodule

### dv/tb_emissary_lru_victim_select.sv
// Testbench for the LRU victim select block: directed and random requests.
module tb_emissary_lru_victim_select;
	import lruvs_pkg::*;

	localparam int NSETS       = NUM_SETS_DEF;
	localparam int NWAYS       = NUM_WAYS_DEF;
	localparam int SBITS       = STAMP_BITS_DEF;
	localparam int SETTLE_CYC  = 40;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [WAY_IDX_W-1:0] way;
		logic                 prot;
	} victim_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  push;
	logic                  full;
	logic [ACTION_W-1:0]   action;
	logic [SET_IDX_W-1:0]  set_index;
	logic [WAY_IDX_W-1:0]  way_index;
	logic                  prefetch_marked;
	logic [PCT_W-1:0]      random_percent;
	logic                  empty;
	logic                  pop;
	logic [WAY_IDX_W-1:0]  victim_way;
	logic                  victim_protected;

	emissary_lru_victim_select dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_addr         (cfg_addr),
		.cfg_wdata        (cfg_wdata),
		.push             (push),
		.full             (full),
		.action           (action),
		.set_index        (set_index),
		.way_index        (way_index),
		.prefetch_marked  (prefetch_marked),
		.random_percent   (random_percent),
		.empty            (empty),
		.pop              (pop),
		.victim_way       (victim_way),
		.victim_protected (victim_protected)
	);

	// Predicted replacement state and registers
	logic [SBITS-1:0]   stamp_mem [NSETS*NWAYS];
	logic               prot_mem  [NSETS*NWAYS];
	logic [SBITS-1:0]   use_ctr;
	logic [LIMIT_W-1:0] reg_limit;
	logic [PCT_W-1:0]   reg_promo;
	logic               reg_pf_en;

	victim_t     expected_victims[$];
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned requests_sent;
	int unsigned victims_checked;
	int unsigned mismatch_count;
	int unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d victims outstanding", cycle_count,
				expected_victims.size());
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk)
		pop <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin : check_victim
		victim_t want;
		if (arst_n && pop && !empty) begin
			if (expected_victims.size() == 0) begin
				$error("victim result with no query outstanding: way %0d protected %0d",
					victim_way, victim_protected);
				mismatch_count++;
			end else begin
				want = expected_victims.pop_front();
				victims_checked++;
				if (victim_way !== want.way) begin
					$error("victim_way: expected %0d, got %0d", want.way, victim_way);
					mismatch_count++;
				end
				if (victim_protected !== want.prot) begin
					$error("victim_protected: expected %0d, got %0d", want.prot,
						victim_protected);
					mismatch_count++;
				end
			end
		end
	end

	function automatic void reset_state();
		for (int i = 0; i < NSETS*NWAYS; i++) begin
			stamp_mem[i] = '0;
			prot_mem[i]  = 1'b0;
		end
		use_ctr   = 1;
		reg_limit = '0;
		reg_promo = '0;
		reg_pf_en = 1'b0;
	endfunction

	// Advance the replacement state by one accepted request; queue the victim of a query.
	function automatic void apply_request(logic [ACTION_W-1:0] act, logic [SET_IDX_W-1:0] set,
			logic [WAY_IDX_W-1:0] way, logic mk, logic [PCT_W-1:0] pct);
		int      base;
		int      idx;
		int      prot_count;
		int      best;
		bit      prefer;
		bit      found;
		bit      promote;
		victim_t v;
		base = (int'(set) % NSETS) * NWAYS;
		idx  = base + int'(way);
		case (act)
			ACT_QUERY: begin
				prot_count = 0;
				for (int w = 0; w < NWAYS; w++)
					prot_count += int'(prot_mem[base + w]);
				prefer = (prot_count < int'(reg_limit)) && (prot_count != NWAYS);
				best  = 0;
				found = 1'b0;
				for (int w = 0; w < NWAYS; w++) begin
					if (!(prefer && prot_mem[base + w]) &&
					    (!found || stamp_mem[base + w] < stamp_mem[base + best])) begin
						best  = w;
						found = 1'b1;
					end
				end
				v.way  = best[WAY_IDX_W-1:0];
				v.prot = prot_mem[base + best];
				expected_victims.push_back(v);
			end
			ACT_TOUCH, ACT_FILL: begin
				stamp_mem[idx] = use_ctr;
				if (use_ctr != '1)
					use_ctr++;
				if (act == ACT_FILL) begin
					if (reg_promo == PCT_ALWAYS)
						promote = 1'b1;
					else if (reg_promo == PCT_NEVER)
						promote = 1'b0;
					else
						promote = (pct < reg_promo);
					prot_mem[idx] = reg_pf_en && mk && promote;
				end
			end
			default: begin
				stamp_mem[idx] = '0;
				prot_mem[idx]  = 1'b0;
			end
		endcase
	endfunction

	task automatic send_request(logic [ACTION_W-1:0] act, logic [SET_IDX_W-1:0] set,
			logic [WAY_IDX_W-1:0] way, logic mk, logic [PCT_W-1:0] pct);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push            <= 1'b1;
		action          <= act;
		set_index       <= set;
		way_index       <= way;
		prefetch_marked <= mk;
		random_percent  <= pct;
		@(posedge clk);
		while (full)
			@(posedge clk);
		apply_request(act, set, way, mk, pct);
		requests_sent++;
	endtask

	// Drop the request line, wait for every victim, then let the back end finish writes.
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (expected_victims.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CFG_LIMIT: reg_limit = val[LIMIT_W-1:0];
			CFG_PROMO: reg_promo = val[PCT_W-1:0];
			CFG_PF_EN: reg_pf_en = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(int limit, int promo, int pf_en);
		settle();
		write_reg(CFG_LIMIT, CFG_DATA_W'(limit));
		write_reg(CFG_PROMO, CFG_DATA_W'(promo));
		write_reg(CFG_PF_EN, CFG_DATA_W'(pf_en));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Untouched sets: every stamp zero, so the lowest way wins the tie.
	task automatic test_reset_state();
		send_request(ACT_QUERY, 6'd0, 3'd0, 1'b0, 7'd0);
		send_request(ACT_QUERY, 6'd63, 3'd7, 1'b1, 7'd127);
	endtask

	task automatic test_lru_order();
		set_config(8, 100, 1);
		send_request(ACT_FILL, 6'd5, 3'd7, 1'b1, 7'd99);
		send_request(ACT_FILL, 6'd5, 3'd0, 1'b1, 7'd0);
		send_request(ACT_TOUCH, 6'd5, 3'd3, 1'b0, 7'd55);
		send_request(ACT_QUERY, 6'd5, 3'd2, 1'b0, 7'd0);
	endtask

	// Promotion above 100 falls back to the plain compare, draws above 99 included.
	task automatic test_promotion();
		set_config(8, 127, 1);
		send_request(ACT_FILL, 6'd9, 3'd2, 1'b1, 7'd127);
		send_request(ACT_FILL, 6'd9, 3'd3, 1'b1, 7'd126);
		send_request(ACT_FILL, 6'd9, 3'd4, 1'b0, 7'd0);
		send_request(ACT_QUERY, 6'd9, 3'd0, 1'b0, 7'd0);
		set_config(0, 0, 1);
		send_request(ACT_FILL, 6'd9, 3'd5, 1'b1, 7'd0);
		send_request(ACT_QUERY, 6'd9, 3'd0, 1'b0, 7'd0);
		set_config(8, 100, 0);
		send_request(ACT_FILL, 6'd12, 3'd1, 1'b1, 7'd0);
		send_request(ACT_QUERY, 6'd12, 3'd0, 1'b0, 7'd0);
	endtask

	// Fully protected set picks the oldest overall; an invalidate reopens one way.
	task automatic test_protection_limit();
		set_config(15, 100, 1);
		for (int w = NWAYS - 1; w >= 0; w--)
			send_request(ACT_FILL, 6'd20, WAY_IDX_W'(w), 1'b1, PCT_W'($urandom_range(99)));
		send_request(ACT_QUERY, 6'd20, 3'd0, 1'b0, 7'd0);
		send_request(ACT_INVAL, 6'd20, 3'd3, 1'b0, 7'd0);
		send_request(ACT_QUERY, 6'd20, 3'd0, 1'b0, 7'd0);
	endtask

	task automatic test_random_traffic(int unsigned send_idle, int unsigned recv_stall,
			int n_segments, int seg_items);
		int                   limit;
		int                   promo;
		int                   sent;
		int unsigned          r;
		logic [SET_IDX_W-1:0] pool [4];
		logic [SET_IDX_W-1:0] set;
		logic [ACTION_W-1:0]  act;
		logic [PCT_W-1:0]     pct;
		for (int s = 0; s < n_segments; s++) begin
			case ($urandom_range(3))
				0: limit = 0;
				1: limit = 15;
				2: limit = NWAYS;
				default: limit = $urandom_range(1, NWAYS - 1);
			endcase
			case ($urandom_range(4))
				0: promo = 0;
				1: promo = 100;
				2: promo = 127;
				3: promo = $urandom_range(1, 99);
				default: promo = $urandom_range(101, 126);
			endcase
			set_config(limit, promo, int'($urandom_range(3) != 0));
			idle_pct  = send_idle;
			stall_pct = recv_stall;
			foreach (pool[i])
				pool[i] = SET_IDX_W'($urandom_range(NSETS - 1));
			sent = 0;
			while (sent < seg_items) begin
				set = ($urandom_range(99) < 75) ? pool[$urandom_range(3)]
					: SET_IDX_W'($urandom_range(NSETS - 1));
				if ($urandom_range(9) == 0) begin
					// fill a whole set, mostly with prefetch-marked requests, to push the protected count up
					for (int w = 0; w < NWAYS; w++)
						send_request(ACT_FILL, set, WAY_IDX_W'(w), $urandom_range(7) != 0,
							PCT_W'($urandom_range(127)));
					send_request(ACT_QUERY, set, WAY_IDX_W'($urandom_range(7)),
						1'($urandom_range(1)), PCT_W'($urandom_range(127)));
					sent += NWAYS + 1;
				end else begin
					r = $urandom_range(99);
					if (r < 25)
						act = ACT_TOUCH;
					else if (r < 60)
						act = ACT_FILL;
					else if (r < 72)
						act = ACT_INVAL;
					else
						act = ACT_QUERY;
					pct = ($urandom_range(4) == 0) ? PCT_W'($urandom_range(127))
						: PCT_W'($urandom_range(99));
					send_request(act, set, WAY_IDX_W'($urandom_range(7)),
						1'($urandom_range(1)), pct);
					sent++;
				end
			end
		end
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_addr        = '0;
		cfg_wdata       = '0;
		push            = 1'b0;
		action          = ACT_TOUCH;
		set_index       = '0;
		way_index       = '0;
		prefetch_marked = 1'b0;
		random_percent  = '0;
		pop             = 1'b0;
		idle_pct        = 0;
		stall_pct       = 0;
		requests_sent   = 0;
		victims_checked = 0;
		mismatch_count  = 0;
		cycle_count     = 0;
		reset_state();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		// hold off while the state memory is cleared
		repeat (2) @(posedge clk);
		while (full)
			@(posedge clk);

		test_reset_state();
		test_lru_order();
		test_promotion();
		test_protection_limit();
		test_random_traffic(0, 0, 4, 103);
		test_random_traffic(47, 0, 4, 103);
		test_random_traffic(0, 47, 4, 103);
		test_random_traffic(22, 22, 4, 103);
		settle();

		$display("sent %0d requests (touch, fill, invalidate, query) over many register settings",
			requests_sent);
		$display("checked %0d victim results under sender gaps and receiver stalls",
			victims_checked);
		if (mismatch_count == 0 && expected_victims.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/lruvs_pkg.sv
src/lruvs_fifo.sv
src/lruvs_front.sv
src/lruvs_back.sv
src/emissary_lru_victim_select.sv
dv/tb_emissary_lru_victim_select.sv
